// ===== design/tksel_pkg.sv =====
// Shared types and constants of the top-k score selector.
// Used by the channel interfaces, the selection cell and the top level.
package tksel_pkg;

    localparam int ID_W       = 24;
    localparam int SCORE_W    = 16;
    localparam int KC_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_THRESHOLD  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_KEEP_COUNT = t_cfg_idx'(1);

    localparam logic [KC_W-1:0] KEEP_COUNT_RESET = KC_W'(16);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_slot;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic shift;
        logic clr;
    } t_cell_ctrl;

endpackage

// ===== design/tksel_if.sv =====
// Valid/ready channel interfaces of the top-k score selector.
// Depends on tksel_pkg for field widths.
interface tksel_item_if import tksel_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    item_id;
    logic [SCORE_W-1:0] item_score;
    logic               set_end;

    modport source (output valid, item_id, item_score, set_end, input ready);
    modport sink   (input valid, item_id, item_score, set_end, output ready);
endinterface

interface tksel_res_if import tksel_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_id;
    logic [SCORE_W-1:0] out_score;
    logic               found;
    logic               final_res;

    modport source (output valid, out_id, out_score, found, final_res, input ready);
    modport sink   (input valid, out_id, out_score, found, final_res, output ready);
endinterface

interface tksel_cfg_if import tksel_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tksel_cell.sv =====
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on tksel_pkg for the slot and control types.
module tksel_cell import tksel_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_slot      i_prev,
    input  logic       i_prev_disp,
    input  t_slot      i_next,
    output t_slot      o_slot,
    output logic       o_disp
);

    t_slot r_slot;
    t_slot n_slot;

    // The new entry ranks ahead of this slot when the slot is empty or the
    // new score is strictly higher; equal scores keep arrival order.
    assign o_disp = i_ctrl.ins && (!r_slot.valid || (i_new.score > r_slot.ent.score));
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.clr) begin
            n_slot.valid = 1'b0;
        end else if (i_ctrl.shift) begin
            n_slot = i_next;
        end else if (o_disp) begin
            if (i_prev_disp) begin
                n_slot = i_prev;
            end else begin
                n_slot.valid = 1'b1;
                n_slot.ent   = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.ent <= n_slot.ent;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

endmodule

// ===== design/top_k_score_select.sv =====
// Top level of the top-k score selector: chain of sorting cells and emit control.
// Depends on tksel_pkg, the channel interfaces in tksel_if and tksel_cell.
//
// Usage: candidates arrive on i_item, one (item_id, item_score) item per
// cycle, the last item of a set marked by set_end. Every item is inserted into
// a chain of MAX_KEEP cells sorted by descending score in the cycle it is
// accepted, so a set streams in at one item per cycle. Equal scores keep
// arrival order; when the chain is full an item enters only if it beats the
// lowest kept score.
// After the item carrying set_end, i_item.ready drops and the chain drains
// from its head into an output register: the first result is registered once
// that register is free, then one result per cycle while o_res.ready is high.
// At most keep_count entries are sent, stopping at the first score below
// score_threshold; if none qualifies a single result with found low is sent.
// final_res marks the last result of the set. The chain is emptied with the
// last result and i_item.ready returns the next cycle. A stalled receiver
// simply holds the output register and freezes the drain. The user must write
// registers on i_cfg (always ready) only while the block is idle; the block
// itself does not enforce it. Reset empties the chain, sets score_threshold
// to 0 and keep_count to 16.
module top_k_score_select import tksel_pkg::*; #(
    parameter int MAX_KEEP = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tksel_item_if.sink        i_item,
    tksel_cfg_if.sink         i_cfg,
    tksel_res_if.source       o_res
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int LW = ((CW > KC_W) ? CW : KC_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [SCORE_W-1:0] r_thr;
    logic [KC_W-1:0]    r_keep;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;

    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_found;
    logic               r_out_final;

    t_slot      slot [MAX_KEEP+1];
    logic       disp [MAX_KEEP+1];
    t_cell_ctrl ctrl;
    t_entry     new_ent;

    logic          in_fire;
    logic          out_free;
    logic          emit_step;
    logic          q0;
    logic          q1;
    logic [LW-1:0] cnt_ext;
    logic [LW-1:0] keep_ext;

    assign i_item.ready = r_state[0];
    assign i_cfg.ready  = 1'b1;
    assign in_fire      = i_item.valid && i_item.ready;

    assign new_ent.id    = i_item.item_id;
    assign new_ent.score = i_item.item_score;

    // Slot past the tail is always empty; it feeds the last cell on a shift.
    assign slot[MAX_KEEP] = '0;
    assign disp[0]        = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
            t_slot prev_slot;
            if (gi == 0) begin : g_head
                assign prev_slot = '0;
            end else begin : g_body
                assign prev_slot = slot[gi-1];
            end
            tksel_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (ctrl),
                .i_new       (new_ent),
                .i_prev      (prev_slot),
                .i_prev_disp (disp[gi]),
                .i_next      (slot[gi+1]),
                .o_slot      (slot[gi]),
                .o_disp      (disp[gi+1])
            );
        end
    endgenerate

    // Head entry qualifies if present, at or above the threshold and still within
    // keep_count; the second entry is checked the same way one count ahead so
    // the final result can be flagged as it is sent.
    assign cnt_ext  = LW'(r_cnt);
    assign keep_ext = LW'(r_keep);
    assign q0 = slot[0].valid && (slot[0].ent.score >= r_thr) && (cnt_ext < keep_ext);
    assign q1 = slot[1].valid && (slot[1].ent.score >= r_thr)
                && ((cnt_ext + LW'(1)) < keep_ext);

    assign out_free  = !r_out_valid || o_res.ready;
    assign emit_step = r_state[1] && out_free;

    assign ctrl.ins   = in_fire;
    assign ctrl.shift = emit_step && q0;
    assign ctrl.clr   = emit_step && !(q0 && q1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && i_item.set_end) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end
            end
            S_EMIT: begin
                if (emit_step) begin
                    if (q0 && q1) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= '0;
            r_keep      <= KEEP_COUNT_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (emit_step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_THRESHOLD) begin
                    r_thr <= i_cfg.data;
                end else if (i_cfg.index == REG_KEEP_COUNT) begin
                    r_keep <= i_cfg.data[KC_W-1:0];
                end
            end
        end
    end

    // Result payload: the head entry, or an empty marker when nothing qualified.
    always_ff @(posedge i_clk) begin
        if (emit_step) begin
            if (q0) begin
                r_out_id    <= slot[0].ent.id;
                r_out_score <= slot[0].ent.score;
                r_out_found <= 1'b1;
                r_out_final <= !q1;
            end else begin
                r_out_id    <= '0;
                r_out_score <= '0;
                r_out_found <= 1'b0;
                r_out_final <= 1'b1;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_id    = r_out_id;
    assign o_res.out_score = r_out_score;
    assign o_res.found     = r_out_found;
    assign o_res.final_res = r_out_final;

endmodule
